### src/fire_spread_grid_step_top_macros.svh
// Assertion macros for the forest-fire grid step block
`ifndef FIRE_SPREAD_GRID_STEP_TOP_MACROS_SVH
`define FIRE_SPREAD_GRID_STEP_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define FSG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define FSG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/fsg_pkg.sv
// Shared types, codes and the cell update rule for the forest-fire grid step
`timescale 1ns / 1ps
`default_nettype none
package fsg_pkg;

	localparam int MAX_COLS_DEF = 1024;
	localparam int ROW_W        = 13;
	localparam int COL_CFG_W    = 11;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 13;
	localparam int CODE_W       = 2;
	localparam int HIST_W       = 2 * CODE_W;

	typedef logic [CODE_W-1:0] code_t;

	localparam code_t CELL_EMPTY   = 2'd0;
	localparam code_t CELL_TREE    = 2'd1;
	localparam code_t CELL_BURNING = 2'd2;
	localparam code_t CELL_BURNED  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPREAD_UP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPREAD_DOWN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPREAD_LEFT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPREAD_RIGHT = 3'd5;

	typedef struct packed {
		logic up;
		logic down;
		logic left;
		logic right;
	} spread_en_t;

	typedef struct packed {
		code_t code;
		logic  lit;
	} update_t;

	function automatic update_t next_code(code_t center, code_t above, code_t below,
			code_t left, code_t right, spread_en_t en);
		update_t u;
		u.code = center;
		u.lit  = 1'b0;
		if (center == CELL_BURNING) begin
			u.code = CELL_BURNED;
		end else if (center == CELL_TREE &&
				((en.down && above == CELL_BURNING) ||
				 (en.up && below == CELL_BURNING) ||
				 (en.right && left == CELL_BURNING) ||
				 (en.left && right == CELL_BURNING))) begin
			u.code = CELL_BURNING;
			u.lit  = 1'b1;
		end
		return u;
	endfunction

endpackage
`default_nettype wire

### src/fsg_if.sv
// Handshake channels of the forest-fire grid step: cells, results, configuration
`timescale 1ns / 1ps
`default_nettype none
interface fsg_cell_if;
	logic                valid;
	logic                ready;
	logic                kind;
	fsg_pkg::code_t      cell_state;

	modport source (output valid, output kind, output cell_state, input ready);
	modport sink (input valid, input kind, input cell_state, output ready);
endinterface

interface fsg_result_if;
	logic                valid;
	logic                ready;
	fsg_pkg::code_t      new_state;
	logic                last_cell;
	logic                any_spread;

	modport source (output valid, output new_state, output last_cell, output any_spread,
		input ready);
	modport sink (input valid, input new_state, input last_cell, input any_spread,
		output ready);
endinterface

interface fsg_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [fsg_pkg::CFG_IDX_W-1:0]    index;
	logic [fsg_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### src/fsg_ram.sv
// Generic RAM: one write port, two registered read ports
`timescale 1ns / 1ps
`default_nettype none
module fsg_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule
`default_nettype wire

### src/fire_spread_grid_step_top.sv
// Top level of the streaming forest-fire grid step
//
// Usage:
//   cells   : one word per grid cell in raster order (kind 0), or a flush word
//             (kind 1) that drains one cell of the last row.
//   results : one word per updated cell, raster order, one row behind the
//             input; the last cell of the grid carries last_cell and any_spread.
//   cfg     : register writes (index, data), always ready; write only while idle.
// Throughput: one word per clock on cells and on results while results is ready.
// Path: the result for cell (r-1, c) appears after cell (r, c) is accepted,
//   through the registered read of the column history RAM and then the output
//   register. Flush words take the same path.
// Cells of row 0 give no result; after the last cell, send one flush word per
//   column to drain the last row. Stray flushes and cells sent while draining
//   are dropped.
// Reset: positions, drain state and the spread flag clear; the history RAM is
//   not cleared and needs no clearing pass, since row 0 writes it first.
// Stall: when results is not ready, the output register and the read stage
//   hold and cells drops ready; no word is lost.
`timescale 1ns / 1ps
`default_nettype none
`include "fire_spread_grid_step_top_macros.svh"
module fire_spread_grid_step_top #(
	parameter int MAX_COLS = fsg_pkg::MAX_COLS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	fsg_cell_if.sink            cells,
	fsg_result_if.source        results,
	fsg_cfg_if.sink             cfg
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int NW = $clog2(MAX_COLS + 1);
	localparam int EW = (NW > fsg_pkg::COL_CFG_W) ? NW : fsg_pkg::COL_CFG_W;
	localparam int RW = fsg_pkg::ROW_W;
	localparam logic [EW-1:0] MAX_COLS_E = EW'(MAX_COLS);

	typedef struct packed {
		logic           valid;
		logic [CW-1:0]  addr;
		logic [CW-1:0]  raddr_b;
		logic           write;
		logic           produce;
		logic           above_ok;
		logic           right_ok;
		logic           left_ok;
		logic           last;
		fsg_pkg::code_t below;
	} stage_t;

	// configuration
	logic [RW-1:0]                   grid_rows_q;
	logic [fsg_pkg::COL_CFG_W-1:0]   grid_cols_q;
	fsg_pkg::spread_en_t             spread_en_q;

	// control state
	logic [RW-1:0]       in_row_q;
	logic [CW-1:0]       in_col_q;
	logic [CW-1:0]       out_col_q;
	logic                drain_q;
	logic                drain_above_q;
	fsg_pkg::code_t      left_q;
	logic                seen_q;

	stage_t              item_s1;
	stage_t              item_nxt;

	logic                fwd_vld_q;
	logic [CW-1:0]       fwd_addr_q;
	logic [fsg_pkg::HIST_W-1:0] fwd_data_q;

	logic                out_valid_q;
	fsg_pkg::code_t      out_state_q;
	logic                out_last_q;
	logic                out_spread_q;

	logic [RW-1:0]       rows_eff;
	logic [EW-1:0]       cols_cfg_e;
	logic [EW-1:0]       cols_eff;
	logic                in_acc;
	logic                take;
	logic [CW-1:0]       col_sel;
	logic [EW-1:0]       col_nxt_e;
	logic [CW-1:0]       col_inc;
	logic                right_ok;
	logic [RW:0]         row_nxt;
	logic                row_end;

	logic                out_free;
	logic                s1_go;
	logic                s1_wr;
	logic [fsg_pkg::HIST_W-1:0] rdata_a;
	logic [fsg_pkg::HIST_W-1:0] rdata_b;
	logic [fsg_pkg::HIST_W-1:0] old_hist;
	logic [fsg_pkg::HIST_W-1:0] rgt_hist;
	logic [fsg_pkg::HIST_W-1:0] wr_hist;
	fsg_pkg::code_t      center;
	fsg_pkg::code_t      above;
	fsg_pkg::code_t      right_nb;
	fsg_pkg::code_t      left_nb;
	fsg_pkg::update_t    upd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= RW'(1);
			grid_cols_q <= fsg_pkg::COL_CFG_W'(1);
			spread_en_q <= '1;
		end else if (cfg.valid) begin
			case (cfg.index)
				fsg_pkg::REG_GRID_ROWS:    grid_rows_q       <= cfg.data[RW-1:0];
				fsg_pkg::REG_GRID_COLS:    grid_cols_q       <= cfg.data[fsg_pkg::COL_CFG_W-1:0];
				fsg_pkg::REG_SPREAD_UP:    spread_en_q.up    <= cfg.data[0];
				fsg_pkg::REG_SPREAD_DOWN:  spread_en_q.down  <= cfg.data[0];
				fsg_pkg::REG_SPREAD_LEFT:  spread_en_q.left  <= cfg.data[0];
				fsg_pkg::REG_SPREAD_RIGHT: spread_en_q.right <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		rows_eff   = (grid_rows_q == '0) ? RW'(1) : grid_rows_q;
		cols_cfg_e = EW'(grid_cols_q);
		if (cols_cfg_e == '0) begin
			cols_eff = EW'(1);
		end else if (cols_cfg_e > MAX_COLS_E) begin
			cols_eff = MAX_COLS_E;
		end else begin
			cols_eff = cols_cfg_e;
		end
	end

	// accept and address stage
	assign out_free    = !out_valid_q || results.ready;
	assign s1_go       = item_s1.valid && (!item_s1.produce || out_free);
	assign cells.ready = !item_s1.valid || s1_go;
	assign in_acc      = cells.valid && cells.ready;
	assign take        = cells.kind ? drain_q : !drain_q;

	always_comb begin
		col_sel   = cells.kind ? out_col_q : in_col_q;
		col_nxt_e = EW'(col_sel) + EW'(1);
		right_ok  = col_nxt_e < cols_eff;
		col_inc   = col_nxt_e[CW-1:0];
		row_nxt   = {1'b0, in_row_q} + (RW + 1)'(1);
		row_end   = row_nxt >= {1'b0, rows_eff};

		item_nxt.valid    = take;
		item_nxt.addr     = col_sel;
		item_nxt.raddr_b  = right_ok ? col_inc : col_sel;
		item_nxt.write    = !cells.kind;
		item_nxt.produce  = cells.kind || (in_row_q != '0);
		item_nxt.above_ok = cells.kind ? drain_above_q : (in_row_q >= RW'(2));
		item_nxt.right_ok = right_ok;
		item_nxt.left_ok  = col_sel != '0;
		item_nxt.last     = cells.kind && !right_ok;
		item_nxt.below    = cells.kind ? fsg_pkg::CELL_EMPTY : cells.cell_state;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q      <= '0;
			in_col_q      <= '0;
			out_col_q     <= '0;
			drain_q       <= 1'b0;
			drain_above_q <= 1'b0;
		end else if (in_acc && take) begin
			if (!cells.kind) begin
				if (!right_ok) begin
					in_col_q <= '0;
					if (row_end) begin
						in_row_q      <= '0;
						drain_q       <= 1'b1;
						drain_above_q <= in_row_q != '0;
						out_col_q     <= '0;
					end else begin
						in_row_q <= row_nxt[RW-1:0];
					end
				end else begin
					in_col_q <= col_inc;
				end
			end else begin
				if (!right_ok) begin
					drain_q   <= 1'b0;
					out_col_q <= '0;
				end else begin
					out_col_q <= col_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (in_acc) begin
			item_s1 <= item_nxt;
		end else if (s1_go) begin
			item_s1.valid <= 1'b0;
		end
	end

	fsg_ram #(
		.WIDTH (fsg_pkg::HIST_W),
		.DEPTH (MAX_COLS)
	) u_hist (
		.clk     (clk),
		.we      (s1_wr),
		.waddr   (item_s1.addr),
		.wdata   (wr_hist),
		.re      (in_acc),
		.raddr_a (col_sel),
		.raddr_b (item_nxt.raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// update stage
	assign s1_wr = s1_go && item_s1.write;

	always_comb begin
		old_hist = (fwd_vld_q && fwd_addr_q == item_s1.addr) ? fwd_data_q : rdata_a;
		rgt_hist = (fwd_vld_q && fwd_addr_q == item_s1.raddr_b) ? fwd_data_q : rdata_b;
		center   = old_hist[fsg_pkg::CODE_W-1:0];
		above    = item_s1.above_ok ? old_hist[fsg_pkg::HIST_W-1:fsg_pkg::CODE_W]
			: fsg_pkg::CELL_EMPTY;
		right_nb = item_s1.right_ok ? rgt_hist[fsg_pkg::CODE_W-1:0] : fsg_pkg::CELL_EMPTY;
		left_nb  = item_s1.left_ok ? left_q : fsg_pkg::CELL_EMPTY;
		wr_hist  = {center, item_s1.below};
		upd      = fsg_pkg::next_code(center, above, item_s1.below, left_nb, right_nb,
			spread_en_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (s1_wr) begin
			fwd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_wr) begin
			fwd_addr_q <= item_s1.addr;
			fwd_data_q <= wr_hist;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= fsg_pkg::CELL_EMPTY;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (s1_go && item_s1.produce) begin
			left_q      <= center;
			out_valid_q <= 1'b1;
			if (item_s1.last) begin
				seen_q <= 1'b0;
			end else if (upd.lit) begin
				seen_q <= 1'b1;
			end
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && item_s1.produce) begin
			out_state_q  <= upd.code;
			out_last_q   <= item_s1.last;
			out_spread_q <= item_s1.last && (seen_q || upd.lit);
		end
	end

	assign results.valid      = out_valid_q;
	assign results.new_state  = out_state_q;
	assign results.last_cell  = out_last_q;
	assign results.any_spread = out_spread_q;

	`FSG_ASSERT_SAME(a_spread_on_last, results.valid && results.any_spread, results.last_cell, "any_spread set off the last cell")
	`FSG_ASSERT_SAME(a_last_is_flush, item_s1.valid && item_s1.last, !item_s1.write && item_s1.produce, "last cell word writes history")
	`FSG_ASSERT_SAME(a_drain_enter, $rose(drain_q), $past(in_acc && !cells.kind), "drain entered without a cell word")
	`FSG_ASSERT_SAME(a_drain_leave, $fell(drain_q), $past(in_acc && cells.kind), "drain left without a flush word")

endmodule
`default_nettype wire

### tb/tb_fire_spread_grid_step_top.sv
// Self-checking testbench for the streaming forest-fire grid step block
`timescale 1ns / 1ps
module tb_fire_spread_grid_step_top;

	localparam logic KIND_CELL  = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;
	localparam int   QUIET_LIMIT = 5000;
	localparam int   DRAIN_SLACK = 6;
	localparam int   RANDOM_WORDS = 800;
	localparam int   DW = fsg_pkg::CFG_DATA_W;

	typedef struct packed {
		fsg_pkg::code_t code;
		logic           last;
		logic           spread;
	} cell_result_t;

	typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_PATTERN, RDY_COIN} ready_mode_t;

	class fire_step_scoreboard;
		logic [fsg_pkg::HIST_W-1:0] history [fsg_pkg::MAX_COLS_DEF];
		fsg_pkg::code_t    left_code;
		int unsigned       in_row, in_col, out_row, out_col;
		bit                lit_seen, draining;
		int unsigned       rows_reg, cols_reg;
		bit                en_up, en_down, en_left, en_right;
		cell_result_t      expected_cells[$];
		int unsigned       errors;

		function new();
			for (int i = 0; i < fsg_pkg::MAX_COLS_DEF; i++) history[i] = '0;
			left_code = fsg_pkg::CELL_EMPTY;
			in_row = 0;
			in_col = 0;
			out_row = 0;
			out_col = 0;
			lit_seen = 0;
			draining = 0;
			rows_reg = 1;
			cols_reg = 1;
			en_up = 1;
			en_down = 1;
			en_left = 1;
			en_right = 1;
			errors = 0;
		endfunction

		function int unsigned eff_rows();
			return (rows_reg == 0) ? 1 : rows_reg;
		endfunction

		function int unsigned eff_cols();
			if (cols_reg == 0) return 1;
			if (cols_reg > fsg_pkg::MAX_COLS_DEF) return fsg_pkg::MAX_COLS_DEF;
			return cols_reg;
		endfunction

		function void write_reg(logic [fsg_pkg::CFG_IDX_W-1:0] idx,
				logic [fsg_pkg::CFG_DATA_W-1:0] data);
			case (idx)
			fsg_pkg::REG_GRID_ROWS: rows_reg = 32'(data);
			fsg_pkg::REG_GRID_COLS: cols_reg = 32'(data[fsg_pkg::COL_CFG_W-1:0]);
			fsg_pkg::REG_SPREAD_UP: en_up = data[0];
			fsg_pkg::REG_SPREAD_DOWN: en_down = data[0];
			fsg_pkg::REG_SPREAD_LEFT: en_left = data[0];
			fsg_pkg::REG_SPREAD_RIGHT: en_right = data[0];
			default: ;
			endcase
		endfunction

		function fsg_pkg::code_t next_cell_code(fsg_pkg::code_t center,
				fsg_pkg::code_t above, fsg_pkg::code_t below, fsg_pkg::code_t left,
				fsg_pkg::code_t right, output bit lit);
			lit = 0;
			if (center == fsg_pkg::CELL_BURNING) return fsg_pkg::CELL_BURNED;
			if (center == fsg_pkg::CELL_TREE &&
					((en_down && above == fsg_pkg::CELL_BURNING) ||
					 (en_up && below == fsg_pkg::CELL_BURNING) ||
					 (en_right && left == fsg_pkg::CELL_BURNING) ||
					 (en_left && right == fsg_pkg::CELL_BURNING))) begin
				lit = 1;
				return fsg_pkg::CELL_BURNING;
			end
			return center;
		endfunction

		function void note_word(logic kind, fsg_pkg::code_t x);
			int unsigned                rows, cols, r, c;
			logic [fsg_pkg::HIST_W-1:0] old;
			fsg_pkg::code_t             center, above, right;
			bit                         lit;
			cell_result_t               res;
			rows = eff_rows();
			cols = eff_cols();
			if (kind == KIND_CELL) begin
				r = in_row;
				c = in_col;
				if (draining || c >= fsg_pkg::MAX_COLS_DEF) return;
				old = history[c];
				if (r >= 1) begin
					center = old[fsg_pkg::CODE_W-1:0];
					above = (r >= 2) ? old[fsg_pkg::HIST_W-1:fsg_pkg::CODE_W]
						: fsg_pkg::CELL_EMPTY;
					right = (c + 1 < cols) ? history[c + 1][fsg_pkg::CODE_W-1:0]
						: fsg_pkg::CELL_EMPTY;
					res.code = next_cell_code(center, above, x,
						(c > 0) ? left_code : fsg_pkg::CELL_EMPTY, right, lit);
					res.last = 0;
					res.spread = 0;
					if (lit) lit_seen = 1;
					left_code = center;
					out_row = r - 1;
					out_col = c + 1;
					expected_cells.push_back(res);
				end
				history[c] = {old[fsg_pkg::CODE_W-1:0], x};
				if (c + 1 >= cols) begin
					in_col = 0;
					if (r + 1 >= rows) begin
						in_row = 0;
						draining = 1;
						out_row = r;
						out_col = 0;
						left_code = fsg_pkg::CELL_EMPTY;
					end else begin
						in_row = r + 1;
					end
				end else begin
					in_col = c + 1;
				end
				return;
			end
			if (!draining) return;
			c = (out_col >= fsg_pkg::MAX_COLS_DEF) ? fsg_pkg::MAX_COLS_DEF - 1 : out_col;
			old = history[c];
			center = old[fsg_pkg::CODE_W-1:0];
			above = (out_row >= 1) ? old[fsg_pkg::HIST_W-1:fsg_pkg::CODE_W]
				: fsg_pkg::CELL_EMPTY;
			right = (c + 1 < cols) ? history[c + 1][fsg_pkg::CODE_W-1:0]
				: fsg_pkg::CELL_EMPTY;
			res.code = next_cell_code(center, above, fsg_pkg::CELL_EMPTY,
				(c > 0) ? left_code : fsg_pkg::CELL_EMPTY, right, lit);
			if (lit) lit_seen = 1;
			left_code = center;
			res.last = (c + 1 >= cols);
			res.spread = res.last && lit_seen;
			if (res.last) begin
				draining = 0;
				lit_seen = 0;
				out_row = 0;
				out_col = 0;
				left_code = fsg_pkg::CELL_EMPTY;
			end else begin
				out_col = c + 1;
			end
			expected_cells.push_back(res);
		endfunction

		function void check_result(fsg_pkg::code_t ns, logic last, logic spread);
			cell_result_t exp_res;
			if (expected_cells.size() == 0) begin
				$error("result word with nothing pending: %s %0d %s %0b %s %0b",
					"new_state", ns, "last_cell", last, "any_spread", spread);
				errors++;
				return;
			end
			exp_res = expected_cells.pop_front();
			if (ns !== exp_res.code) begin
				$error("new_state: expected %0d, actual %0d", exp_res.code, ns);
				errors++;
			end
			if (last !== exp_res.last) begin
				$error("last_cell: expected %0b, actual %0b", exp_res.last, last);
				errors++;
			end
			if (spread !== exp_res.spread) begin
				$error("any_spread: expected %0b, actual %0b", exp_res.spread, spread);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	fsg_cell_if   cells_if();
	fsg_result_if results_if();
	fsg_cfg_if    cfg_if();

	fire_spread_grid_step_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cells   (cells_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	fire_step_scoreboard model;
	int unsigned         quiet_cycles = 0;
	int unsigned         burst_left = 0;
	int unsigned         word_count = 0;
	int unsigned         stall_left = 0;
	ready_mode_t         stall_mode = RDY_ALWAYS;
	logic [15:0]         stall_pat = 16'h00f1;

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= ready_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(16, 160);
			stall_pat <= 16'($urandom) | 16'h0001;
		end else begin
			stall_left <= stall_left - 1;
			stall_pat <= {stall_pat[0], stall_pat[15:1]};
		end
		case (stall_mode)
		RDY_ALWAYS: results_if.ready <= 1'b1;
		RDY_MOSTLY: results_if.ready <= ($urandom_range(0, 3) != 0);
		RDY_PATTERN: results_if.ready <= stall_pat[0];
		default: results_if.ready <= ($urandom_range(0, 1) == 1);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (results_if.valid && results_if.ready)
				model.check_result(results_if.new_state, results_if.last_cell,
					results_if.any_spread);
			if (cells_if.valid && cells_if.ready)
				model.note_word(cells_if.kind, cells_if.cell_state);
			if (cfg_if.valid && cfg_if.ready)
				model.write_reg(cfg_if.index, cfg_if.data);
			if ((results_if.valid && results_if.ready) || (cells_if.valid && cells_if.ready) ||
					(cfg_if.valid && cfg_if.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic fsg_pkg::code_t random_code(int unsigned burn_pct);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < burn_pct) return fsg_pkg::CELL_BURNING;
		if (roll < burn_pct + 45) return fsg_pkg::CELL_TREE;
		if (roll < burn_pct + 65) return fsg_pkg::CELL_EMPTY;
		return fsg_pkg::CELL_BURNED;
	endfunction

	task automatic send_word(input logic kind, input fsg_pkg::code_t code);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				cells_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		cells_if.valid <= 1'b1;
		cells_if.kind <= kind;
		cells_if.cell_state <= code;
		@(posedge clk);
		while (!cells_if.ready) @(posedge clk);
		burst_left--;
	endtask

	task automatic settle();
		cells_if.valid <= 1'b0;
		@(posedge clk);
		burst_left = 0;
		while (model.expected_cells.size() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(input logic [fsg_pkg::CFG_IDX_W-1:0] idx,
			input logic [fsg_pkg::CFG_DATA_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int unsigned rows, input int unsigned cols,
			input int unsigned up, input int unsigned down, input int unsigned left,
			input int unsigned right);
		settle();
		write_reg(fsg_pkg::REG_GRID_ROWS, DW'(rows));
		write_reg(fsg_pkg::REG_GRID_COLS, DW'(cols));
		write_reg(fsg_pkg::REG_SPREAD_UP, DW'(up));
		write_reg(fsg_pkg::REG_SPREAD_DOWN, DW'(down));
		write_reg(fsg_pkg::REG_SPREAD_LEFT, DW'(left));
		write_reg(fsg_pkg::REG_SPREAD_RIGHT, DW'(right));
	endtask

	// one full step: every cell, then one flush per column of the last row; when noisy, stray words are mixed in
	task automatic run_grid(input fsg_pkg::code_t grid[$], input bit noisy);
		int unsigned cols;
		cols = model.eff_cols();
		foreach (grid[i]) begin
			if (noisy && $urandom_range(0, 19) == 0)
				send_word(KIND_FLUSH, fsg_pkg::code_t'($urandom_range(0, 3)));
			send_word(KIND_CELL, grid[i]);
		end
		for (int unsigned j = 0; j < cols; j++) begin
			if (noisy && $urandom_range(0, 19) == 0)
				send_word(KIND_CELL, fsg_pkg::code_t'($urandom_range(0, 3)));
			send_word(KIND_FLUSH, fsg_pkg::code_t'($urandom_range(0, 3)));
		end
		if (noisy && $urandom_range(0, 9) == 0)
			send_word(KIND_FLUSH, fsg_pkg::code_t'($urandom_range(0, 3)));
		word_count += grid.size() + cols;
	endtask

	task automatic run_random_grid(input bit noisy);
		fsg_pkg::code_t grid[$];
		int unsigned    burn_pct, n;
		burn_pct = $urandom_range(3, 40);
		n = model.eff_rows() * model.eff_cols();
		for (int unsigned i = 0; i < n; i++) grid.push_back(random_code(burn_pct));
		run_grid(grid, noisy);
	endtask

	initial begin
		fsg_pkg::code_t grid[$];
		int unsigned    rows, cols;
		model = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cells_if.valid = 1'b0;
		cells_if.kind = KIND_CELL;
		cells_if.cell_state = fsg_pkg::CELL_EMPTY;
		cfg_if.valid = 1'b0;
		cfg_if.index = fsg_pkg::REG_GRID_ROWS;
		cfg_if.data = '0;
		results_if.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single cell at reset sizes, with a stray flush ahead of it
		send_word(KIND_FLUSH, fsg_pkg::CELL_BURNED);
		grid = '{fsg_pkg::CELL_BURNING};
		run_grid(grid, 0);

		// burning center lights the plus shape, corners hold
		configure(3, 3, 1, 1, 1, 1);
		grid = '{fsg_pkg::CELL_TREE, fsg_pkg::CELL_TREE, fsg_pkg::CELL_TREE,
			fsg_pkg::CELL_TREE, fsg_pkg::CELL_BURNING, fsg_pkg::CELL_TREE,
			fsg_pkg::CELL_TREE, fsg_pkg::CELL_TREE, fsg_pkg::CELL_TREE};
		run_grid(grid, 0);

		// leftward spread only, with a cell dropped while draining
		configure(1, 3, 0, 0, 1, 0);
		send_word(KIND_CELL, fsg_pkg::CELL_TREE);
		send_word(KIND_CELL, fsg_pkg::CELL_BURNING);
		send_word(KIND_CELL, fsg_pkg::CELL_TREE);
		send_word(KIND_FLUSH, fsg_pkg::CELL_EMPTY);
		send_word(KIND_CELL, fsg_pkg::CELL_BURNING);
		send_word(KIND_FLUSH, fsg_pkg::CELL_TREE);
		send_word(KIND_FLUSH, fsg_pkg::CELL_BURNED);

		word_count = 0;
		while (word_count < RANDOM_WORDS) begin
			rows = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 6);
			cols = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 9);
			configure(rows, cols, $urandom_range(0, 1), $urandom_range(0, 1),
				$urandom_range(0, 1), $urandom_range(0, 1));
			repeat ($urandom_range(1, 3)) run_random_grid(1);
		end

		configure(12, 1, 1, 1, 1, 1);
		run_random_grid(0);
		configure(1, 40, 1, 0, 1, 1);
		run_random_grid(1);
		configure(2, 32, 0, 0, 0, 0);
		run_random_grid(1);
		configure(4, 5, 1, 1, 0, 1);
		run_random_grid(1);

		settle();
		if (model.errors == 0 && model.expected_cells.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
